### hw/rtl/htmc_pkg.sv
// Shared types, constants and the control-store program for the hover thrust
// mode controller. No dependencies; every other file of the block uses it.
package htmc_pkg;

    localparam int ACC_W = 56;
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 21;
    localparam int RAMP_W = 11;
    localparam int R2_W = 21;
    localparam logic [31:0] RAMP_TICKS = 32'd1024;

    typedef enum logic [2:0] {
        MODE_CUTOFF   = 3'd0,
        MODE_ABORT    = 3'd1,
        MODE_STARTING = 3'd2,
        MODE_HOVERING = 3'd3,
        MODE_GLIDING  = 3'd4
    } mode_t;

    typedef struct packed {
        logic [31:0]        height;
        logic [31:0]        time_now;
        logic [31:0]        angular_speed;
        logic signed [31:0] vertical_speed;
    } in_item_t;

    typedef struct packed {
        mode_t              mode;
        logic signed [47:0] force_res;
        logic               force_valid;
    } out_item_t;

    // register map
    localparam logic [3:0] REG_DESIRED_HEIGHT   = 4'd0;
    localparam logic [3:0] REG_STIFFNESS        = 4'd1;
    localparam logic [3:0] REG_DAMPING_COEF     = 4'd2;
    localparam logic [3:0] REG_WEIGHT           = 4'd3;
    localparam logic [3:0] REG_CUTOFF_HEIGHT    = 4'd4;
    localparam logic [3:0] REG_CUTOFF_ANG_SPEED = 4'd5;
    localparam logic [3:0] REG_GLIDE_HEIGHT     = 4'd6;
    localparam logic [3:0] REG_RESTART_TIME     = 4'd7;

    typedef struct packed {
        logic [31:0] desired_height;
        logic [31:0] stiffness;
        logic [31:0] damping_coef;
        logic [31:0] weight;
        logic [31:0] cutoff_height;
        logic [31:0] cutoff_ang_speed;
        logic [31:0] glide_height;
        logic [15:0] restart_time;
    } cfg_t;

    localparam logic [31:0] DESIRED_HEIGHT_RST = 32'd6553600;

    // datapath control fields
    typedef enum logic [2:0] {
        A_ZERO, A_DIFF, A_VS, A_RAMP, A_PD_LO, A_PD_HI
    } a_sel_t;

    typedef enum logic [2:0] {
        B_ZERO, B_STIFF_LO, B_STIFF_HI, B_DAMP_LO, B_DAMP_HI, B_RAMP, B_R2
    } b_sel_t;

    typedef enum logic [2:0] {
        ACC_NONE, ACC_CLEAR, ACC_ADD, ACC_SUB, ACC_ADD_S16, ACC_SUB_S16,
        ACC_ADD_S20, ACC_ADD_WEIGHT
    } acc_op_t;

    typedef enum logic [2:0] {
        DP_NONE, DP_ELAPSED, DP_DECIDE, DP_DIFF, DP_SAVE, DP_EMIT
    } dp_op_t;

    typedef enum logic [1:0] {
        JMP_NONE, JMP_UNPOWERED, JMP_NOT_START
    } jmp_t;

    typedef logic [3:0] step_t;

    typedef struct packed {
        a_sel_t  a_sel;
        b_sel_t  b_sel;
        acc_op_t acc_op;
        dp_op_t  dp_op;
        jmp_t    jmp;
        step_t   target;
    } uctl_t;

    typedef struct packed {
        logic powered;
        logic starting;
        logic out_free;
    } dp_stat_t;

    localparam step_t STEP_ELAPSED = 4'd0;
    localparam step_t STEP_DECIDE  = 4'd1;
    localparam step_t STEP_DIFF    = 4'd2;
    localparam step_t STEP_K_LO    = 4'd3;
    localparam step_t STEP_K_HI    = 4'd4;
    localparam step_t STEP_D_LO    = 4'd5;
    localparam step_t STEP_D_HI    = 4'd6;
    localparam step_t STEP_SQUARE  = 4'd7;
    localparam step_t STEP_SAVE    = 4'd8;
    localparam step_t STEP_R_LO    = 4'd9;
    localparam step_t STEP_R_HI    = 4'd10;
    localparam step_t STEP_R_ACC   = 4'd11;
    localparam step_t STEP_WEIGHT  = 4'd12;
    localparam step_t STEP_EMIT    = 4'd13;

    localparam uctl_t UOP_NOP = '{A_ZERO, B_ZERO, ACC_NONE, DP_NONE, JMP_NONE, STEP_ELAPSED};

    // Multiply steps register a product that the next step folds into the accumulator;
    // the ramp square is only saved. Spring and damping coefficients go in as 16-bit halves.
    function automatic uctl_t uop_rom(step_t pc);
        uctl_t w;
        w = UOP_NOP;
        unique case (pc)
            STEP_ELAPSED: w.dp_op = DP_ELAPSED;
            STEP_DECIDE:  w.dp_op = DP_DECIDE;
            STEP_DIFF:
            begin
                w.dp_op  = DP_DIFF;
                w.acc_op = ACC_CLEAR;
                w.jmp    = JMP_UNPOWERED;
                w.target = STEP_EMIT;
            end
            STEP_K_LO:
            begin
                w.a_sel = A_DIFF;
                w.b_sel = B_STIFF_LO;
            end
            STEP_K_HI:
            begin
                w.a_sel  = A_DIFF;
                w.b_sel  = B_STIFF_HI;
                w.acc_op = ACC_ADD_S16;
            end
            STEP_D_LO:
            begin
                w.a_sel  = A_VS;
                w.b_sel  = B_DAMP_LO;
                w.acc_op = ACC_ADD;
            end
            STEP_D_HI:
            begin
                w.a_sel  = A_VS;
                w.b_sel  = B_DAMP_HI;
                w.acc_op = ACC_SUB_S16;
            end
            STEP_SQUARE:
            begin
                w.a_sel  = A_RAMP;
                w.b_sel  = B_RAMP;
                w.acc_op = ACC_SUB;
                w.jmp    = JMP_NOT_START;
                w.target = STEP_WEIGHT;
            end
            STEP_SAVE:
            begin
                w.dp_op  = DP_SAVE;
                w.acc_op = ACC_CLEAR;
            end
            STEP_R_LO:
            begin
                w.a_sel = A_PD_LO;
                w.b_sel = B_R2;
            end
            STEP_R_HI:
            begin
                w.a_sel  = A_PD_HI;
                w.b_sel  = B_R2;
                w.acc_op = ACC_ADD_S20;
            end
            STEP_R_ACC:   w.acc_op = ACC_ADD;
            STEP_WEIGHT:  w.acc_op = ACC_ADD_WEIGHT;
            STEP_EMIT:    w.dp_op = DP_EMIT;
            default:      w = UOP_NOP;
        endcase
        return w;
    endfunction

endpackage

### hw/rtl/hover_thrust_mode_controller_top.sv
// Hover thrust mode controller: one result beat per input beat.
// Microcode program on one shared 34x21 multiplier: cutoff and abort jump
// from the difference step to emit, hovering and gliding jump past the ramp
// scaling, starting runs it all. One beat in flight: the next is accepted in
// the cycle after the result registers; the emit step holds while output stalls.
// Reset clears sequencer, output valid, cutoff stamp; sets held height, config to defaults.
module hover_thrust_mode_controller_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  htmc_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output htmc_pkg::out_item_t out_data,
    input  logic                cfg_we,
    input  logic [3:0]          cfg_index,
    input  logic [31:0]         cfg_data
);

    htmc_pkg::cfg_t     cfg;
    htmc_pkg::uctl_t    ctl;
    htmc_pkg::dp_stat_t stat;
    logic               busy;
    logic               accept;

    assign in_stall = busy;
    assign accept   = in_valid && !busy;

    htmc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    htmc_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .stat  (stat),
        .ctl   (ctl),
        .busy  (busy)
    );

    htmc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .in_item   (in_data),
        .cfg       (cfg),
        .ctl       (ctl),
        .out_stall (out_stall),
        .stat      (stat),
        .out_valid (out_valid),
        .out_item  (out_data)
    );

endmodule

### hw/rtl/htmc_cfg.sv
// Configuration register file of the hover thrust mode controller.
// Depends on htmc_pkg for the register map and the cfg_t bundle.
module htmc_cfg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [3:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    output htmc_pkg::cfg_t      cfg
);

    htmc_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.desired_height   <= htmc_pkg::DESIRED_HEIGHT_RST;
            cfg_reg.stiffness        <= 32'd65536;
            cfg_reg.damping_coef     <= 32'd65536;
            cfg_reg.weight           <= 32'd0;
            cfg_reg.cutoff_height    <= 32'hFFFF_FFFF;
            cfg_reg.cutoff_ang_speed <= 32'hFFFF_FFFF;
            cfg_reg.glide_height     <= 32'hFFFF_FFFF;
            cfg_reg.restart_time     <= 16'd1024;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                htmc_pkg::REG_DESIRED_HEIGHT:   cfg_reg.desired_height   <= cfg_data;
                htmc_pkg::REG_STIFFNESS:        cfg_reg.stiffness        <= cfg_data;
                htmc_pkg::REG_DAMPING_COEF:     cfg_reg.damping_coef     <= cfg_data;
                htmc_pkg::REG_WEIGHT:           cfg_reg.weight           <= cfg_data;
                htmc_pkg::REG_CUTOFF_HEIGHT:    cfg_reg.cutoff_height    <= cfg_data;
                htmc_pkg::REG_CUTOFF_ANG_SPEED: cfg_reg.cutoff_ang_speed <= cfg_data;
                htmc_pkg::REG_GLIDE_HEIGHT:     cfg_reg.glide_height     <= cfg_data;
                htmc_pkg::REG_RESTART_TIME:     cfg_reg.restart_time     <= cfg_data[15:0];
                default: ; // drop writes outside the map
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### hw/rtl/htmc_seq.sv
// Microcode sequencer: step counter, control store lookup and jumps.
// Depends on htmc_pkg for the control word, the program and the status bundle.
module htmc_seq (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  htmc_pkg::dp_stat_t stat,
    output htmc_pkg::uctl_t    ctl,
    output logic               busy
);

    htmc_pkg::step_t pc_reg, pc_next;
    logic            busy_reg, busy_next;
    htmc_pkg::uctl_t word;
    logic            take_jump;

    assign word = htmc_pkg::uop_rom(pc_reg);

    always_comb
    begin
        case (word.jmp)
            htmc_pkg::JMP_UNPOWERED: take_jump = !stat.powered;
            htmc_pkg::JMP_NOT_START: take_jump = !stat.starting;
            default:                 take_jump = 1'b0;
        endcase
    end

    always_comb
    begin
        pc_next   = pc_reg;
        busy_next = busy_reg;
        if (!busy_reg)
        begin
            if (start)
            begin
                busy_next = 1'b1;
                pc_next   = htmc_pkg::STEP_ELAPSED;
            end
        end
        else if (word.dp_op == htmc_pkg::DP_EMIT)
        begin
            // hold until the output register is free
            if (stat.out_free)
            begin
                busy_next = 1'b0;
            end
        end
        else if (take_jump)
        begin
            pc_next = word.target;
        end
        else
        begin
            pc_next = pc_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= htmc_pkg::STEP_ELAPSED;
            busy_reg <= 1'b0;
        end
        else
        begin
            pc_reg   <= pc_next;
            busy_reg <= busy_next;
        end
    end

    assign ctl  = busy_reg ? word : htmc_pkg::UOP_NOP;
    assign busy = busy_reg;

    a_start_pc: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy_reg) |=> (busy_reg && pc_reg == htmc_pkg::STEP_ELAPSED))
        else $error("sequencer did not enter the program at its first step");

    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && word.dp_op != htmc_pkg::DP_EMIT) |=> (busy_reg && !$stable(pc_reg)))
        else $error("sequencer stalled outside the emit step");

    a_idle_nop: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (ctl.dp_op == htmc_pkg::DP_NONE && ctl.acc_op == htmc_pkg::ACC_NONE))
        else $error("control word active while idle");

endmodule

### hw/rtl/htmc_dp.sv
// Datapath: input latch, mode decision, shared 34x21 multiplier, accumulator
// and output register. Depends on htmc_pkg for types and control codes.
module htmc_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  htmc_pkg::in_item_t  in_item,
    input  htmc_pkg::cfg_t      cfg,
    input  htmc_pkg::uctl_t     ctl,
    input  logic                out_stall,
    output htmc_pkg::dp_stat_t  stat,
    output logic                out_valid,
    output htmc_pkg::out_item_t out_item
);

    localparam int AW = htmc_pkg::ACC_W;
    localparam logic signed [AW-1:0] FORCE_MAX = {{(AW-47){1'b0}}, {47{1'b1}}};
    localparam logic signed [AW-1:0] FORCE_MIN = {{(AW-47){1'b1}}, {47{1'b0}}};

    htmc_pkg::in_item_t in_reg;
    logic [31:0]        elapsed_reg;
    logic [31:0]        stamp_reg;
    logic [31:0]        held_reg;
    logic [31:0]        used_h_reg;
    htmc_pkg::mode_t    mode_reg;
    logic               powered_reg;
    logic [htmc_pkg::RAMP_W-1:0] ramp_reg;
    logic signed [32:0] diff_reg;
    logic signed [AW-1:0] pd_reg;
    logic [htmc_pkg::R2_W-1:0] r2_reg;
    logic signed [AW-1:0] prod_reg, prod_next;
    logic signed [AW-1:0] acc_reg, acc_next;
    logic               out_valid_reg;
    htmc_pkg::out_item_t out_reg;

    logic signed [htmc_pkg::MUL_A_W-1:0] op_a;
    logic [htmc_pkg::MUL_B_W-1:0]        op_b;

    logic [32:0]        ramp_full;
    logic               in_cooldown, tripped, ramp_short;
    htmc_pkg::mode_t    mode_next;
    logic signed [47:0] force_sat;
    logic               out_free, emit;

    // mode decision from the latched beat and the elapsed time
    always_comb
    begin
        ramp_full   = {1'b0, elapsed_reg} - {17'd0, cfg.restart_time};
        in_cooldown = ramp_full[32] || (ramp_full == 33'd0);
        tripped     = !(in_reg.height < cfg.cutoff_height &&
                        in_reg.angular_speed < cfg.cutoff_ang_speed);
        ramp_short  = ramp_full[31:0] <= htmc_pkg::RAMP_TICKS;
        if (in_cooldown)
            mode_next = htmc_pkg::MODE_CUTOFF;
        else if (tripped)
            mode_next = htmc_pkg::MODE_ABORT;
        else if (ramp_short)
            mode_next = htmc_pkg::MODE_STARTING;
        else if (in_reg.height < cfg.glide_height)
            mode_next = htmc_pkg::MODE_HOVERING;
        else
            mode_next = htmc_pkg::MODE_GLIDING;
    end

    always_comb
    begin
        case (ctl.a_sel)
            htmc_pkg::A_DIFF:  op_a = {diff_reg[32], diff_reg};
            htmc_pkg::A_VS:    op_a = {{2{in_reg.vertical_speed[31]}}, in_reg.vertical_speed};
            htmc_pkg::A_RAMP:  op_a = {23'd0, ramp_reg};
            htmc_pkg::A_PD_LO: op_a = {14'd0, pd_reg[19:0]};
            htmc_pkg::A_PD_HI: op_a = pd_reg[53:20];
            default:           op_a = '0;
        endcase
        case (ctl.b_sel)
            htmc_pkg::B_STIFF_LO: op_b = {5'd0, cfg.stiffness[15:0]};
            htmc_pkg::B_STIFF_HI: op_b = {5'd0, cfg.stiffness[31:16]};
            htmc_pkg::B_DAMP_LO:  op_b = {5'd0, cfg.damping_coef[15:0]};
            htmc_pkg::B_DAMP_HI:  op_b = {5'd0, cfg.damping_coef[31:16]};
            htmc_pkg::B_RAMP:     op_b = {10'd0, ramp_reg};
            htmc_pkg::B_R2:       op_b = r2_reg;
            default:              op_b = '0;
        endcase
    end

    assign prod_next = op_a * $signed({1'b0, op_b});

    always_comb
    begin
        case (ctl.acc_op)
            htmc_pkg::ACC_CLEAR:      acc_next = '0;
            htmc_pkg::ACC_ADD:        acc_next = acc_reg + prod_reg;
            htmc_pkg::ACC_SUB:        acc_next = acc_reg - prod_reg;
            htmc_pkg::ACC_ADD_S16:    acc_next = acc_reg + (prod_reg >>> 16);
            htmc_pkg::ACC_SUB_S16:    acc_next = acc_reg - (prod_reg >>> 16);
            htmc_pkg::ACC_ADD_S20:    acc_next = acc_reg + (prod_reg >>> 20);
            htmc_pkg::ACC_ADD_WEIGHT: acc_next = acc_reg + $signed({24'd0, cfg.weight});
            default:                  acc_next = acc_reg;
        endcase
    end

    always_comb
    begin
        if (acc_reg > FORCE_MAX)
            force_sat = FORCE_MAX[47:0];
        else if (acc_reg < FORCE_MIN)
            force_sat = FORCE_MIN[47:0];
        else
            force_sat = acc_reg[47:0];
    end

    assign out_free = !out_valid_reg || !out_stall;
    assign emit     = (ctl.dp_op == htmc_pkg::DP_EMIT) && out_free;

    // control and persistent state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stamp_reg     <= 32'd0;
            held_reg      <= htmc_pkg::DESIRED_HEIGHT_RST;
            mode_reg      <= htmc_pkg::MODE_CUTOFF;
            powered_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.dp_op == htmc_pkg::DP_DECIDE)
            begin
                mode_reg    <= mode_next;
                powered_reg <= !in_cooldown && !tripped;
                if (mode_next == htmc_pkg::MODE_ABORT)
                    stamp_reg <= in_reg.time_now;
                if (mode_next == htmc_pkg::MODE_HOVERING)
                    held_reg <= in_reg.height;
            end
            if (emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (load)
            in_reg <= in_item;
        if (ctl.dp_op == htmc_pkg::DP_ELAPSED)
            elapsed_reg <= in_reg.time_now - stamp_reg;
        if (ctl.dp_op == htmc_pkg::DP_DECIDE)
        begin
            ramp_reg   <= ramp_full[htmc_pkg::RAMP_W-1:0];
            used_h_reg <= (mode_next == htmc_pkg::MODE_GLIDING) ? held_reg : in_reg.height;
        end
        if (ctl.dp_op == htmc_pkg::DP_DIFF)
            diff_reg <= $signed({1'b0, cfg.desired_height}) - $signed({1'b0, used_h_reg});
        if (ctl.dp_op == htmc_pkg::DP_SAVE)
        begin
            pd_reg <= acc_reg;
            r2_reg <= prod_reg[htmc_pkg::R2_W-1:0];
        end
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        if (emit)
        begin
            out_reg.mode        <= mode_reg;
            out_reg.force_res   <= powered_reg ? force_sat : 48'sd0;
            out_reg.force_valid <= powered_reg;
        end
    end

    assign stat.powered  = powered_reg;
    assign stat.starting = (mode_reg == htmc_pkg::MODE_STARTING);
    assign stat.out_free = out_free;
    assign out_valid     = out_valid_reg;
    assign out_item      = out_reg;

    a_valid_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.force_valid ==
            (out_reg.mode == htmc_pkg::MODE_STARTING ||
             out_reg.mode == htmc_pkg::MODE_HOVERING ||
             out_reg.mode == htmc_pkg::MODE_GLIDING)))
        else $error("force_valid disagrees with the reported mode");

    a_unpowered_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.force_valid) |-> (out_reg.force_res == 48'sd0))
        else $error("unpowered beat carries a nonzero force");

    a_abort_stamp: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.dp_op == htmc_pkg::DP_DECIDE && mode_next == htmc_pkg::MODE_ABORT)
        |=> (stamp_reg == $past(in_reg.time_now)))
        else $error("abort did not record the cutoff time");

endmodule

### tb/hover_thrust_mode_controller_top_tb.sv
// Self-checking testbench for the hover thrust mode controller top level.
// Drives ticks through a burst-mode driver, predicts mode and thrust per tick
// and checks every result beat; depends on htmc_pkg and the top-level RTL.
`timescale 1ns / 1ps

module hover_thrust_mode_controller_top_tb;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int TAIL_CYCLES = 20;
    localparam logic [3:0] REG_UNMAPPED_LO = 4'd8;
    localparam logic signed [95:0] FORCE_HI = 96'sh7FFF_FFFF_FFFF;
    localparam logic signed [95:0] FORCE_LO = -FORCE_HI - 96'sd1;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    htmc_pkg::in_item_t  in_data = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    htmc_pkg::out_item_t out_data;
    logic                cfg_we = 1'b0;
    logic [3:0]          cfg_index = '0;
    logic [31:0]         cfg_data = '0;

    htmc_pkg::in_item_t  pending_ticks[$];
    htmc_pkg::out_item_t expected_thrust[$];
    htmc_pkg::cfg_t      cfg_mirror;
    logic [31:0]         stamp_mirror;
    logic [31:0]         held_mirror;
    logic [31:0]         tick_time = '0;
    int                  mismatches = 0;
    int                  cycle_count = 0;
    int                  burst_left = 0;
    int                  gap_left = 0;
    int                  stall_run = 0;

    hover_thrust_mode_controller_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [31:0] sat_up(logic [31:0] base, logic [31:0] off);
        logic [32:0] s;
        s = {1'b0, base} + {1'b0, off};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic logic [31:0] sat_down(logic [31:0] base, logic [31:0] off);
        return (base > off) ? base - off : 32'd0;
    endfunction

    // Mode choice and PD thrust for one tick; updates the cutoff stamp and
    // the held height as the block does.
    function automatic htmc_pkg::out_item_t predict_thrust(htmc_pkg::in_item_t tk);
        htmc_pkg::out_item_t r;
        logic [31:0]         elapsed;
        logic [31:0]         ramp;
        logic [31:0]         used_h;
        logic signed [95:0]  diff;
        logic signed [95:0]  spring;
        logic signed [95:0]  damp;
        logic signed [95:0]  pd;
        logic signed [95:0]  frc;
        r.mode = htmc_pkg::MODE_CUTOFF;
        r.force_res = '0;
        r.force_valid = 1'b0;
        elapsed = tk.time_now - stamp_mirror;
        if (elapsed <= {16'd0, cfg_mirror.restart_time})
        begin
            r.mode = htmc_pkg::MODE_CUTOFF;
        end
        else if (tk.height >= cfg_mirror.cutoff_height
                 || tk.angular_speed >= cfg_mirror.cutoff_ang_speed)
        begin
            r.mode = htmc_pkg::MODE_ABORT;
            stamp_mirror = tk.time_now;
        end
        else
        begin
            ramp = elapsed - {16'd0, cfg_mirror.restart_time};
            used_h = tk.height;
            if (ramp <= htmc_pkg::RAMP_TICKS)
            begin
                r.mode = htmc_pkg::MODE_STARTING;
            end
            else if (tk.height < cfg_mirror.glide_height)
            begin
                r.mode = htmc_pkg::MODE_HOVERING;
                held_mirror = tk.height;
            end
            else
            begin
                r.mode = htmc_pkg::MODE_GLIDING;
                used_h = held_mirror;
            end
            diff = $signed({64'd0, cfg_mirror.desired_height}) - $signed({64'd0, used_h});
            spring = (diff * $signed({64'd0, cfg_mirror.stiffness})) >>> 16;
            damp = ($signed({{64{tk.vertical_speed[31]}}, tk.vertical_speed})
                    * $signed({64'd0, cfg_mirror.damping_coef})) >>> 16;
            pd = spring - damp;
            if (r.mode == htmc_pkg::MODE_STARTING)
                pd = (pd * $signed({64'd0, ramp * ramp})) >>> 20;
            frc = pd + $signed({64'd0, cfg_mirror.weight});
            if (frc > FORCE_HI)
                frc = FORCE_HI;
            if (frc < FORCE_LO)
                frc = FORCE_LO;
            r.force_res = frc[47:0];
            r.force_valid = 1'b1;
        end
        return r;
    endfunction

    // Time advances in steps scaled to the cooldown and the ramp so that every mode comes
    // round; heights and speeds cluster near the thresholds.
    function automatic htmc_pkg::in_item_t rand_tick();
        htmc_pkg::in_item_t tk;
        int unsigned        pick;
        int unsigned        span;
        span = (int'(cfg_mirror.restart_time) + int'(htmc_pkg::RAMP_TICKS)) / 8 + 1;
        pick = $urandom_range(0, 99);
        if (pick < 3)
            tick_time = $urandom();
        else
            tick_time = tick_time + $urandom_range(0, span);
        tk.time_now = tick_time;
        pick = $urandom_range(0, 99);
        if (pick < 6)
            tk.height = sat_up(cfg_mirror.cutoff_height, $urandom_range(0, 255));
        else if (pick < 22)
            tk.height = sat_up(cfg_mirror.glide_height, $urandom_range(0, 32'h00FF_FFFF));
        else if (pick < 30)
            tk.height = $urandom();
        else if (pick < 32)
            tk.height = '0;
        else if (pick < 66)
            tk.height = sat_up(cfg_mirror.desired_height, $urandom_range(0, 32'h003F_FFFF));
        else
            tk.height = sat_down(cfg_mirror.desired_height, $urandom_range(0, 32'h003F_FFFF));
        pick = $urandom_range(0, 99);
        if (pick < 5)
            tk.angular_speed = sat_up(cfg_mirror.cutoff_ang_speed, $urandom_range(0, 255));
        else if (pick < 15 || cfg_mirror.cutoff_ang_speed == 0)
            tk.angular_speed = $urandom();
        else
            tk.angular_speed = $urandom_range(0, cfg_mirror.cutoff_ang_speed - 1);
        pick = $urandom_range(0, 99);
        if (pick < 10)
            tk.vertical_speed = $urandom();
        else if (pick < 12)
            tk.vertical_speed = 32'h8000_0000;
        else if (pick < 14)
            tk.vertical_speed = 32'h7FFF_FFFF;
        else
            tk.vertical_speed = $urandom_range(0, 32'h007F_FFFF) - 32'h0040_0000;
        return tk;
    endfunction

    function automatic void push_tick(logic [31:0] h, logic [31:0] t, logic [31:0] a,
                                      logic [31:0] v);
        htmc_pkg::in_item_t tk;
        tk.height = h;
        tk.time_now = t;
        tk.angular_speed = a;
        tk.vertical_speed = v;
        pending_ticks.push_back(tk);
    endfunction

    task automatic write_reg(logic [3:0] idx, logic [31:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Restart time goes in with junk in the upper half, which must be dropped.
    task automatic apply_settings(htmc_pkg::cfg_t s);
        logic [15:0] junk;
        junk = 16'($urandom());
        write_reg(htmc_pkg::REG_DESIRED_HEIGHT, s.desired_height);
        write_reg(htmc_pkg::REG_STIFFNESS, s.stiffness);
        write_reg(htmc_pkg::REG_DAMPING_COEF, s.damping_coef);
        write_reg(htmc_pkg::REG_WEIGHT, s.weight);
        write_reg(htmc_pkg::REG_CUTOFF_HEIGHT, s.cutoff_height);
        write_reg(htmc_pkg::REG_CUTOFF_ANG_SPEED, s.cutoff_ang_speed);
        write_reg(htmc_pkg::REG_GLIDE_HEIGHT, s.glide_height);
        write_reg(htmc_pkg::REG_RESTART_TIME, {junk, s.restart_time});
        write_reg(REG_UNMAPPED_LO | 4'($urandom_range(0, 7)), $urandom());
        @(negedge clk);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (pending_ticks.size() != 0 || in_valid || expected_thrust.size() != 0)
            @(negedge clk);
    endtask

    task automatic run_random(htmc_pkg::cfg_t s, int count);
        wait_idle();
        apply_settings(s);
        repeat (count) pending_ticks.push_back(rand_tick());
    endtask

    // Mirror register writes and predict each accepted tick.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_mirror = '{htmc_pkg::DESIRED_HEIGHT_RST, 32'd65536, 32'd65536, 32'd0,
                           32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd1024};
            stamp_mirror = '0;
            held_mirror = htmc_pkg::DESIRED_HEIGHT_RST;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    htmc_pkg::REG_DESIRED_HEIGHT:   cfg_mirror.desired_height = cfg_data;
                    htmc_pkg::REG_STIFFNESS:        cfg_mirror.stiffness = cfg_data;
                    htmc_pkg::REG_DAMPING_COEF:     cfg_mirror.damping_coef = cfg_data;
                    htmc_pkg::REG_WEIGHT:           cfg_mirror.weight = cfg_data;
                    htmc_pkg::REG_CUTOFF_HEIGHT:    cfg_mirror.cutoff_height = cfg_data;
                    htmc_pkg::REG_CUTOFF_ANG_SPEED: cfg_mirror.cutoff_ang_speed = cfg_data;
                    htmc_pkg::REG_GLIDE_HEIGHT:     cfg_mirror.glide_height = cfg_data;
                    htmc_pkg::REG_RESTART_TIME:     cfg_mirror.restart_time = cfg_data[15:0];
                    default:                        ;
                endcase
            end
            if (in_valid && !in_stall)
                expected_thrust.push_back(predict_thrust(in_data));
        end
    end

    // Sender: bursts of beats separated by random gaps; hold while stalled.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (gap_left != 0)
            begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_ticks.size() != 0)
            begin
                in_valid <= 1'b1;
                in_data <= pending_ticks.pop_front();
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall in runs of random length, mostly open.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_run <= 0;
        end
        else if (stall_run == 0)
        begin
            out_stall <= ($urandom_range(0, 9) < 4);
            stall_run <= $urandom_range(1, 16);
        end
        else
        begin
            stall_run <= stall_run - 1;
        end
    end

    always @(posedge clk)
    begin : check_results
        htmc_pkg::out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_thrust.size() == 0)
            begin
                $display("%0t: unexpected beat, expected none, got mode %0d force %0d valid %0b",
                         $time, out_data.mode, out_data.force_res, out_data.force_valid);
                mismatches++;
            end
            else
            begin
                want = expected_thrust.pop_front();
                if (out_data.mode !== want.mode)
                begin
                    $display("%0t: mode expected %0d got %0d", $time, want.mode, out_data.mode);
                    mismatches++;
                end
                if (out_data.force_res !== want.force_res)
                begin
                    $display("%0t: force_res expected %0d got %0d",
                             $time, want.force_res, out_data.force_res);
                    mismatches++;
                end
                if (out_data.force_valid !== want.force_valid)
                begin
                    $display("%0t: force_valid expected %0b got %0b",
                             $time, want.force_valid, out_data.force_valid);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        htmc_pkg::cfg_t typical;
        htmc_pkg::cfg_t s;
        logic [31:0]    dh;
        logic [31:0]    base;

        dh = htmc_pkg::DESIRED_HEIGHT_RST;
        // Reset settings: cooldown edge, ramp ends, abort on either limit,
        // time running backward, field extremes.
        push_tick(dh, 32'd0, 32'd0, 32'd0);
        push_tick(32'd0, 32'd1024, 32'd0, 32'd0);
        push_tick(32'd0, 32'd1025, 32'd0, 32'h7FFF_FFFF);
        push_tick(32'hFFFF_FFFE, 32'd1500, 32'hFFFF_FFFE, 32'h8000_0000);
        push_tick(dh, 32'd2048, 32'd0, 32'd0);
        push_tick(dh + 32'd1, 32'd2049, 32'd0, 32'hFFFF_FFFF);
        push_tick(32'hFFFF_FFFF, 32'd3000, 32'd0, 32'd0);
        push_tick(32'd0, 32'd3000, 32'd0, 32'd0);
        push_tick(32'd0, 32'd4025, 32'hFFFF_FFFF, 32'd0);
        push_tick(dh - 32'd65536, 32'd4024, 32'd0, 32'd65536);
        push_tick(32'd0, 32'hFFFF_FFFF, 32'd0, 32'd0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        wait_idle();
        typical = '{32'd6553600, 32'd131072, 32'd32768, 32'd642253,
                    32'd13107200, 32'd23592960, 32'd9830400, 16'd512};
        apply_settings(typical);
        // Hover to latch a height, glide on it, then abort and restart.
        base = 32'h4000_0000;
        push_tick(typical.desired_height - 32'd327680, base, 32'd0, 32'd0);
        push_tick(typical.glide_height, base + 32'h10, typical.cutoff_ang_speed - 32'd1,
                  32'h0001_0000);
        push_tick(typical.cutoff_height - 32'd1, base + 32'h20, 32'd0, 32'h8000_0000);
        push_tick(typical.cutoff_height, base + 32'h30, 32'd0, 32'd0);
        push_tick(typical.desired_height, base + 32'h30 + 32'd512, 32'd0, 32'd0);
        push_tick(typical.desired_height, base + 32'h30 + 32'd513, 32'd0, 32'h7FFF_FFFF);
        tick_time = base + 32'h30 + 32'd513;
        repeat (300) pending_ticks.push_back(rand_tick());

        // Top of every range but the glide height: positive saturation, longest cooldown.
        run_random('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 16'hFFFF}, 200);
        // Zero target with full gains: negative saturation, no cooldown.
        run_random('{32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0,
                     32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h4000_0000, 16'd0}, 150);
        run_random('{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 16'd0}, 40);

        repeat (6)
        begin
            s.desired_height = $urandom_range(32'h0001_0000, 32'h03E8_0000);
            s.stiffness = ($urandom_range(0, 7) == 0) ? $urandom()
                                                       : $urandom_range(0, 32'h0040_0000);
            s.damping_coef = ($urandom_range(0, 7) == 0) ? $urandom()
                                                          : $urandom_range(0, 32'h0040_0000);
            s.weight = ($urandom_range(0, 7) == 0) ? $urandom()
                                                    : $urandom_range(0, 32'h0064_0000);
            s.glide_height = sat_up(s.desired_height,
                                    $urandom_range(32'h0001_0000, 32'h0032_0000));
            s.cutoff_height = sat_up(s.glide_height,
                                     $urandom_range(32'h0001_0000, 32'h0064_0000));
            s.cutoff_ang_speed = $urandom_range(32'h0001_0000, 32'h02D0_0000);
            s.restart_time = 16'($urandom_range(0, 4096));
            run_random(s, 150);
        end

        run_random(typical, 120);

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
